// ----- rtl/core/rmbs_pkg.sv -----
// Shared types and constants of the region map burst splitter.
// Used by the shared adder unit, the top level and the port checker.
// No dependencies.
package rmbs_pkg;

    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 30;
    localparam int ALU_W     = DATA_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int REGION_W  = 2;

    // Configuration register indexes. The region sizes follow REG_SIZE_A in order.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_A       = 3'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             borrow;
        logic             zero;
    } t_alu_res;

endpackage

// ----- rtl/core/rmbs_alu.sv -----
// Shared add/subtract unit of the region map burst splitter.
// Depends on rmbs_pkg for the request and result types.
module rmbs_alu (
    input  rmbs_pkg::t_alu_req i_req,
    output rmbs_pkg::t_alu_res o_res
);

    logic [rmbs_pkg::ALU_W:0] wide;

    always_comb begin
        unique case (i_req.op)
            rmbs_pkg::ALU_ADD: wide = {1'b0, i_req.a} + {1'b0, i_req.b};
            rmbs_pkg::ALU_SUB: wide = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:           wide = '0;
        endcase
    end

    // The borrow bit is the carry out of the subtraction, so it means a < b.
    assign o_res.value  = wide[rmbs_pkg::ALU_W-1:0];
    assign o_res.borrow = (i_req.op == rmbs_pkg::ALU_SUB) && wide[rmbs_pkg::ALU_W];
    assign o_res.zero   = (wide[rmbs_pkg::ALU_W-1:0] == '0);

endmodule

// ----- rtl/core/region_map_burst_splitter.sv -----
// Top level of the region map burst splitter: sequencer, datapath registers and config.
// Depends on rmbs_pkg and instantiates rmbs_alu.
//
//  Channel   | Handshake          | Payload
//  ----------+--------------------+------------------------------------------------------
//  access    | start, busy        | i_command, i_start_address, i_byte_count
//  result    | o_strobe (1 cycle) | o_is_write, o_region_index, o_region_offset,
//            |                    | o_chunk_length, o_bytes_done, o_status, o_last
//  config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An access transaction is taken when start is high and busy is low. An empty map or a
// zero length is answered in the next cycle and the block stays ready. Otherwise a
// transaction runs through the region sums, the remainder steps over the ADDR_BITS bits
// when wrapping is on and the total size is not zero, the region search steps and per
// chunk the room, offset, clip and emit steps. Every step uses the one shared adder.
// Results are strobed for one cycle each and cannot be held off. The reset is
// synchronous and active low; it clears the sequencer and all configuration registers.
module region_map_burst_splitter #(
    parameter int MAX_REGIONS = 4,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [rmbs_pkg::DATA_W-1:0]         i_start_address,
    input  logic [rmbs_pkg::DATA_W-1:0]         i_byte_count,
    input  logic                                i_cfg_we,
    input  logic [rmbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rmbs_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_is_write,
    output logic [rmbs_pkg::REGION_W-1:0]       o_region_index,
    output logic [rmbs_pkg::SIZE_W-1:0]         o_region_offset,
    output logic [rmbs_pkg::DATA_W-1:0]         o_chunk_length,
    output logic [rmbs_pkg::DATA_W-1:0]         o_bytes_done,
    output logic [rmbs_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_last
);

    localparam int DW    = rmbs_pkg::DATA_W;
    localparam int SW    = rmbs_pkg::SIZE_W;
    localparam int AW    = rmbs_pkg::ALU_W;
    localparam int IDX_W = $clog2(MAX_REGIONS + 1);
    localparam int SEL_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int BIT_W = $clog2(ADDR_BITS);
    localparam logic [DW-1:0] ADDR_MASK = DW'((64'd1 << ADDR_BITS) - 64'd1);

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_FIND = 8'b0000_1000,
        S_ROOM = 8'b0001_0000,
        S_OFFS = 8'b0010_0000,
        S_CLIP = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    // Control and configuration registers.
    t_state                          r_state, n_state;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [BIT_W-1:0]                r_bit, n_bit;
    logic                            r_strobe, n_strobe;
    logic [DW-1:0]                   r_base_offset;
    logic                            r_wrap_enable;
    logic [rmbs_pkg::COUNT_W-1:0]    r_region_count;
    logic [SW-1:0]                   r_size [MAX_REGIONS];

    // Datapath registers.
    logic                            r_is_write, n_is_write;
    logic [DW-1:0]                   r_addr, n_addr;
    logic [DW-1:0]                   r_mrem, n_mrem;
    logic [DW-1:0]                   r_total, n_total;
    logic [DW-1:0]                   r_ends [MAX_REGIONS];
    logic [DW-1:0]                   n_ends [MAX_REGIONS];
    logic [DW-1:0]                   r_rem, n_rem;
    logic [DW-1:0]                   r_done, n_done;
    logic [DW-1:0]                   r_room, n_room;
    logic [SW-1:0]                   r_off, n_off;
    logic [DW-1:0]                   r_chunk, n_chunk;
    logic                            r_last, n_last;

    // Result registers.
    logic [rmbs_pkg::REGION_W-1:0]   r_out_region, n_out_region;
    logic [SW-1:0]                   r_out_offset, n_out_offset;
    logic [DW-1:0]                   r_out_chunk, n_out_chunk;
    logic [rmbs_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                            r_out_last, n_out_last;

    logic [IDX_W-1:0]                cnt;
    logic [SEL_W-1:0]                sel;
    logic [IDX_W-1:0]                idx_inc;
    logic [AW-1:0]                   mod_shift;
    logic [DW-1:0]                   mod_next;
    rmbs_pkg::t_alu_req              alu_req;
    rmbs_pkg::t_alu_res              alu_res;

    rmbs_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Counts above the number of built regions act as that number.
    assign cnt = (r_region_count > rmbs_pkg::COUNT_W'(MAX_REGIONS)) ?
                 IDX_W'(MAX_REGIONS) : IDX_W'(r_region_count);

    // The region select stays in range even while the index points one past the map.
    assign sel     = (r_idx < IDX_W'(MAX_REGIONS)) ? r_idx[SEL_W-1:0] : '0;
    assign idx_inc = r_idx + 1'b1;

    // One step of the restoring remainder: bring in the next dividend bit, then
    // subtract the total size if it fits.
    assign mod_shift = {r_mrem, r_addr[ADDR_BITS-1]};
    assign mod_next  = alu_res.borrow ? mod_shift[DW-1:0] : alu_res.value[DW-1:0];

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_bit        = r_bit;
        n_strobe     = 1'b0;
        n_is_write   = r_is_write;
        n_addr       = r_addr;
        n_mrem       = r_mrem;
        n_total      = r_total;
        n_ends       = r_ends;
        n_rem        = r_rem;
        n_done       = r_done;
        n_room       = r_room;
        n_off        = r_off;
        n_chunk      = r_chunk;
        n_last       = r_last;
        n_out_region = r_out_region;
        n_out_offset = r_out_offset;
        n_out_chunk  = r_out_chunk;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        alu_req.op   = rmbs_pkg::ALU_ADD;
        alu_req.a    = '0;
        alu_req.b    = '0;

        unique case (r_state)
            S_IDLE: begin
                // Remove the base offset while waiting, so it is ready on acceptance.
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = AW'(i_start_address);
                alu_req.b  = AW'(r_base_offset);
                if (start) begin
                    n_is_write = i_command;
                    n_rem      = i_byte_count;
                    n_done     = '0;
                    n_addr     = alu_res.value[DW-1:0] & ADDR_MASK;
                    n_idx      = '0;
                    n_total    = '0;
                    if (cnt == '0 || i_byte_count == '0) begin
                        n_strobe     = 1'b1;
                        n_out_region = '0;
                        n_out_offset = '0;
                        n_out_chunk  = '0;
                        n_out_status = rmbs_pkg::STATUS_EMPTY;
                        n_out_last   = 1'b1;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // Running sum of sizes gives the end address of each region.
                alu_req.op   = rmbs_pkg::ALU_ADD;
                alu_req.a    = AW'(r_total);
                alu_req.b    = AW'(r_size[sel]);
                n_ends[sel]  = alu_res.value[DW-1:0];
                n_total      = alu_res.value[DW-1:0];
                if (idx_inc == cnt) begin
                    n_idx = '0;
                    if (r_wrap_enable && !alu_res.zero) begin
                        n_state = S_MOD;
                        n_bit   = BIT_W'(ADDR_BITS - 1);
                        n_mrem  = '0;
                    end else begin
                        n_state = S_FIND;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_MOD: begin
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = mod_shift;
                alu_req.b  = AW'(r_total);
                if (r_bit == '0) begin
                    n_addr  = mod_next;
                    n_state = S_FIND;
                end else begin
                    n_addr = r_addr << 1;
                    n_mrem = mod_next;
                    n_bit  = r_bit - 1'b1;
                end
            end
            S_FIND: begin
                // Walk the regions until one ends above the address; zero-size ones
                // never satisfy this and are skipped.
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = AW'(r_addr);
                alu_req.b  = AW'(r_ends[sel]);
                if (r_idx == cnt) begin
                    n_strobe     = 1'b1;
                    n_out_region = '0;
                    n_out_offset = '0;
                    n_out_chunk  = '0;
                    n_out_status = rmbs_pkg::STATUS_NOT_MAPPED;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else if (alu_res.borrow) begin
                    n_state = S_ROOM;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_ROOM: begin
                // Bytes left in the region from the current address.
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = AW'(r_ends[sel]);
                alu_req.b  = AW'(r_addr);
                n_room     = alu_res.value[DW-1:0];
                n_state    = S_OFFS;
            end
            S_OFFS: begin
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = AW'(r_size[sel]);
                alu_req.b  = AW'(r_room);
                n_off      = alu_res.value[SW-1:0];
                n_state    = S_CLIP;
            end
            S_CLIP: begin
                // The chunk is the smaller of the remaining length and the room left.
                alu_req.op = rmbs_pkg::ALU_SUB;
                alu_req.a  = AW'(r_rem);
                alu_req.b  = AW'(r_room);
                if (alu_res.borrow || alu_res.zero) begin
                    n_chunk = r_rem;
                    n_last  = 1'b1;
                    n_rem   = '0;
                end else begin
                    n_chunk = r_room;
                    n_last  = 1'b0;
                    n_rem   = alu_res.value[DW-1:0];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                alu_req.op   = rmbs_pkg::ALU_ADD;
                alu_req.a    = AW'(r_done);
                alu_req.b    = AW'(r_chunk);
                n_done       = alu_res.value[DW-1:0];
                n_strobe     = 1'b1;
                n_out_region = rmbs_pkg::REGION_W'(sel);
                n_out_offset = r_off;
                n_out_chunk  = r_chunk;
                n_out_status = rmbs_pkg::STATUS_OK;
                n_out_last   = r_last;
                // A chunk that is not the last one always runs to the region end.
                n_addr       = r_ends[sel];
                n_state      = r_last ? S_IDLE : S_FIND;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_bit          <= '0;
            r_strobe       <= 1'b0;
            r_base_offset  <= '0;
            r_wrap_enable  <= 1'b0;
            r_region_count <= '0;
            for (int k = 0; k < MAX_REGIONS; k++) begin
                r_size[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_bit    <= n_bit;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rmbs_pkg::REG_BASE_OFFSET:  r_base_offset  <= i_cfg_data;
                    rmbs_pkg::REG_WRAP_ENABLE:  r_wrap_enable  <= i_cfg_data[0];
                    rmbs_pkg::REG_REGION_COUNT: r_region_count <=
                        i_cfg_data[rmbs_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            // Sizes of regions that are not built are dropped.
            for (int k = 0; k < MAX_REGIONS; k++) begin
                if (i_cfg_we &&
                    i_cfg_index == rmbs_pkg::CFG_IDX_W'(rmbs_pkg::REG_SIZE_A + k)) begin
                    r_size[k] <= i_cfg_data[SW-1:0];
                end
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_is_write   <= n_is_write;
        r_addr       <= n_addr;
        r_mrem       <= n_mrem;
        r_total      <= n_total;
        r_ends       <= n_ends;
        r_rem        <= n_rem;
        r_done       <= n_done;
        r_room       <= n_room;
        r_off        <= n_off;
        r_chunk      <= n_chunk;
        r_last       <= n_last;
        r_out_region <= n_out_region;
        r_out_offset <= n_out_offset;
        r_out_chunk  <= n_out_chunk;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_is_write      = r_is_write;
    assign o_region_index  = r_out_region;
    assign o_region_offset = r_out_offset;
    assign o_chunk_length  = r_out_chunk;
    assign o_bytes_done    = r_done;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

// ----- rtl/core/rmbs_checker.sv -----
// Port-level checker for the region map burst splitter, bound to the top level.
// Depends on rmbs_pkg for the status codes.
module rmbs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic [rmbs_pkg::DATA_W-1:0]       o_chunk_length,
    input logic [rmbs_pkg::STATUS_W-1:0]     o_status,
    input logic                              o_last
);

    // A result that is not a chunk always closes the transaction and carries no bytes.
    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != rmbs_pkg::STATUS_OK |-> o_last && o_chunk_length == '0)
        else $error("non-chunk result is not final or has a length");

    // A chunk always moves at least one byte.
    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == rmbs_pkg::STATUS_OK |-> o_chunk_length != '0)
        else $error("empty chunk emitted");

    // While more chunks of a transaction follow, the block stays busy.
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("block idle in the middle of a transaction");

    // An accepted transaction either keeps the block busy or is answered at once as empty.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || (o_strobe && o_status == rmbs_pkg::STATUS_EMPTY && o_last))
        else $error("accepted transaction neither started nor answered");

endmodule

bind region_map_burst_splitter rmbs_checker u_rmbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_chunk_length (o_chunk_length),
    .o_status       (o_status),
    .o_last         (o_last)
);
